[design/msu_pkg.sv]
// Shared types and constants for the moving average smoother.
// Depends on nothing; every other file of the block imports it.
package msu_pkg;

    // Fixed field widths of the sample and result requests.
    localparam int SAMPLE_BITS    = 16;
    localparam int WIN_BITS       = 7;
    localparam int MAX_WINDOW_DEF = 100;

    // Configuration port layout and register indexes.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = WIN_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 1'b1;

    // Mode codes and register reset values.
    localparam logic MODE_TRAILING = 1'b0;
    localparam logic MODE_CENTERED = 1'b1;
    localparam logic                MODE_RESET   = MODE_TRAILING;
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 7'd10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          last_out;
        logic                          too_short;
    } rsp_t;

    // Source selection for the result register.
    typedef enum logic [1:0] {
        RSP_AVG,
        RSP_PASS,
        RSP_SHORT
    } rsp_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     update;
        logic     restart;
        logic     div_start;
        logic     tail_init;
        logic     tail_read;
        logic     tail_sub;
        logic     rsp_load;
        rsp_sel_t rsp_sel;
        logic     rsp_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass;
        logic mode1;
        logic emit;
        logic short_stream;
        logic last_item;
        logic tail_last;
        logic rsp_free;
        logic div_busy;
    } stat_t;

endpackage

[design/moving_average_smoother_unit.sv]
// Moving average smoother: one request in flight at a time. An averaged result comes from
// the radix-2 divider, which yields one quotient bit per cycle; a request with no result
// and a pass-through request do not use the divider. In centered mode the tail results
// follow the last sample's own result one after another; a stalled result delays all of
// these. Reset (rst_n low, asynchronous) clears the stream state and sets mode 0, window
// 10.
module moving_average_smoother_unit
    import msu_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  req_t                     req,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output rsp_t                     rsp,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    msu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    msu_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[design/msu_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on msu_pkg for the sample width.
module msu_div
    import msu_pkg::*;
#(
    parameter int SUM_W = 23,
    parameter int DIV_W = 7
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic        [DIV_W-1:0]       divisor,
    output logic                          busy,
    output logic signed [SAMPLE_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] quo_reg;
    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic             neg_reg;
    logic             zero_reg;

    logic [SUM_W-1:0]       mag;
    logic [DIV_W:0]         shifted;
    logic [DIV_W:0]         diff;
    logic                   fits;
    logic [SAMPLE_BITS-1:0] q_low;

    // Magnitude of the dividend and one trial subtraction per step.
    always_comb
    begin
        mag     = dividend[SUM_W-1] ? unsigned'(-dividend) : unsigned'(dividend);
        shifted = {rem_reg[DIV_W-1:0], quo_reg[SUM_W-1]};
        fits    = (shifted >= {1'b0, den_reg});
        diff    = shifted - {1'b0, den_reg};
    end

    // Step counter.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Quotient and partial remainder shift together.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= mag;
            rem_reg  <= '0;
            den_reg  <= divisor;
            neg_reg  <= dividend[SUM_W-1];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff : shifted;
        end
    end

    // Restore the sign; an empty window reads as zero.
    always_comb
    begin
        q_low = quo_reg[SAMPLE_BITS-1:0];
        if (zero_reg)
        begin
            quotient = '0;
        end
        else if (neg_reg)
        begin
            quotient = signed'(-q_low);
        end
        else
        begin
            quotient = signed'(q_low);
        end
    end

    assign busy = busy_reg;

endmodule

[design/msu_dp.sv]
// Datapath: configuration registers, delay line memory, running sum, divider
// and result register. Depends on msu_pkg and msu_div.
module msu_dp
    import msu_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  req_t                     req,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output rsp_t                     rsp
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    logic                          mode_reg;
    logic [WIN_BITS-1:0]           window_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]              fill_reg;
    logic [PTR_W-1:0]              wp_reg;
    logic [PTR_W-1:0]              tp_reg;
    logic [CNT_W-1:0]              k_reg;
    logic [CNT_W-1:0]              den_reg;
    logic                          emit_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic                          rsp_valid_reg;
    rsp_t                          rsp_reg;
    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [WIN_BITS-1:0]     win_clip;
    logic [CNT_W-1:0]        w_eff;
    logic [CNT_W-1:0]        half_w;
    logic                    mode1;
    logic                    full_before;
    logic signed [SUM_W-1:0] smp_ext;
    logic signed [SUM_W-1:0] rd_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] sum_upd;
    logic [CNT_W-1:0]        fill_upd;
    logic [PTR_W-1:0]        wp_inc;
    logic [PTR_W-1:0]        tp_inc;
    logic                    emit_upd;
    logic [PTR_W-1:0]        rd_addr;
    logic                    rsp_free;
    logic                    div_busy;
    logic signed [SAMPLE_BITS-1:0] quotient;

    // Effective window: zero acts as one, large values clip to the depth.
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_clip = WIN_BITS'(1);
        end
        else if (window_reg > WIN_BITS'(MAX_WINDOW))
        begin
            win_clip = WIN_BITS'(MAX_WINDOW);
        end
        else
        begin
            win_clip = window_reg;
        end
        w_eff  = win_clip[CNT_W-1:0];
        half_w = w_eff >> 1;
        mode1  = (mode_reg == MODE_CENTERED);
    end

    // Running sum update for one new sample, pointer wrap logic and the emit decision.
    always_comb
    begin
        smp_ext     = {{(SUM_W-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        rd_ext      = {{(SUM_W-SAMPLE_BITS){rd_reg[SAMPLE_BITS-1]}}, rd_reg};
        full_before = (fill_reg == w_eff);
        old_ext     = full_before ? rd_ext : '0;
        sum_upd     = sum_reg - old_ext + smp_ext;
        fill_upd    = full_before ? fill_reg : fill_reg + 1'b1;
        wp_inc      = (CNT_W'(wp_reg) + 1'b1 == w_eff) ? '0 : wp_reg + 1'b1;
        tp_inc      = (CNT_W'(tp_reg) + 1'b1 == w_eff) ? '0 : tp_reg + 1'b1;
        if (mode1)
        begin
            emit_upd = full_before || (fill_reg > half_w);
        end
        else
        begin
            emit_upd = (fill_upd == w_eff);
        end
    end

    // Configuration, stream state and tail walk registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            window_reg <= WINDOW_RESET;
            sum_reg    <= '0;
            fill_reg   <= '0;
            wp_reg     <= '0;
            tp_reg     <= '0;
            k_reg      <= '0;
            den_reg    <= '0;
            emit_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_WINDOW: window_reg <= cfg_data[WIN_BITS-1:0];
            endcase
            sum_reg  <= '0;
            fill_reg <= '0;
            wp_reg   <= '0;
        end
        else if (cmd.restart)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            wp_reg   <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg  <= sum_upd;
            fill_reg <= fill_upd;
            wp_reg   <= wp_inc;
            den_reg  <= fill_upd;
            emit_reg <= emit_upd;
        end
        else if (cmd.tail_init)
        begin
            tp_reg <= wp_reg;
            k_reg  <= '0;
        end
        else if (cmd.tail_sub)
        begin
            sum_reg <= sum_reg - rd_ext;
            den_reg <= den_reg - 1'b1;
            tp_reg  <= tp_inc;
            k_reg   <= k_reg + 1'b1;
        end
    end

    // Capture the accepted request.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= req.sample;
            last_reg   <= req.last;
        end
    end

    // Delay line: one write port, one registered read port.
    assign rd_addr = cmd.tail_read ? tp_reg : wp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            mem[wp_reg] <= sample_reg;
        end
        if (cmd.accept || cmd.tail_read)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    msu_div #(
        .SUM_W (SUM_W),
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Result register, free when empty or being taken this cycle.
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_reg.last_out  <= cmd.rsp_last;
            rsp_reg.too_short <= (cmd.rsp_sel == RSP_SHORT);
            case (cmd.rsp_sel)
                RSP_AVG:   rsp_reg.average <= quotient;
                RSP_PASS:  rsp_reg.average <= sample_reg;
                default:   rsp_reg.average <= '0;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.pass         = mode1 && (w_eff == CNT_W'(1));
        stat.mode1        = mode1;
        stat.emit         = emit_reg;
        stat.short_stream = (fill_reg != w_eff);
        stat.last_item    = last_reg;
        stat.tail_last    = (k_reg == half_w + 1'b1);
        stat.rsp_free     = rsp_free;
        stat.div_busy     = div_busy;
    end

endmodule

[design/msu_ctrl.sv]
// Controller state machine that sequences one request at a time through the
// datapath. Depends on msu_pkg for the command and status structs.
module msu_ctrl
    import msu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PASS     = 4'd1;
    localparam logic [3:0] S_UPD      = 4'd2;
    localparam logic [3:0] S_DIV_GO   = 4'd3;
    localparam logic [3:0] S_DIV_WAIT = 4'd4;
    localparam logic [3:0] S_POST     = 4'd5;
    localparam logic [3:0] S_SHORT    = 4'd6;
    localparam logic [3:0] S_TREAD    = 4'd7;
    localparam logic [3:0] S_TSUB     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       tail_reg, tail_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        tail_next  = tail_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.pass ? S_PASS : S_UPD;
                end
            end
            S_PASS:
            begin
                if (stat.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    cmd.rsp_sel  = RSP_PASS;
                    cmd.rsp_last = stat.last_item;
                    cmd.restart  = stat.last_item;
                    state_next   = S_IDLE;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                if (tail_reg || stat.emit)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_DIV_WAIT:
            begin
                if (!stat.div_busy && stat.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    cmd.rsp_sel  = RSP_AVG;
                    if (tail_reg)
                    begin
                        cmd.rsp_last = stat.tail_last;
                        if (stat.tail_last)
                        begin
                            cmd.restart = 1'b1;
                            tail_next   = 1'b0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_TREAD;
                        end
                    end
                    else
                    begin
                        cmd.rsp_last = stat.last_item && !stat.mode1;
                        state_next   = S_POST;
                    end
                end
            end
            S_POST:
            begin
                if (!stat.last_item)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.short_stream)
                begin
                    state_next = S_SHORT;
                end
                else if (stat.mode1)
                begin
                    cmd.tail_init = 1'b1;
                    tail_next     = 1'b1;
                    state_next    = S_TREAD;
                end
                else
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SHORT:
            begin
                if (stat.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    cmd.rsp_sel  = RSP_SHORT;
                    cmd.rsp_last = 1'b1;
                    cmd.restart  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TREAD:
            begin
                cmd.tail_read = 1'b1;
                state_next    = S_TSUB;
            end
            S_TSUB:
            begin
                cmd.tail_sub = 1'b1;
                state_next   = S_DIV_GO;
            end
            default:
            begin
                tail_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

[design/msu_chk.sv]
// Port-level checker for the moving average smoother, bound to the top level.
// Depends on msu_pkg for the request and result types.
module msu_chk
    import msu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp,
    input logic cfg_valid,
    input logic cfg_ready
);

    // Only one request is worked on at a time.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another was still in progress");

    // A waiting request keeps its payload.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed or dropped while waiting");

    // A short stream result is always final and carries a zero average.
    a_short_final: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.too_short |-> rsp.last_out && (rsp.average == '0))
        else $error("too_short result without last_out or with nonzero average");

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    // Register writes never wait.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write was held off");

endmodule

bind moving_average_smoother_unit msu_chk u_msu_chk (.*);

[sim/tb_top.sv]
// Self-checking testbench for moving_average_smoother_unit: directed stimulus table, then
// random streams, results scored against a behavioral predictor or, for typed rows, the table.
// Depends on msu_pkg and the moving_average_smoother_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msu_pkg::*;

    localparam int RANDOM_ITEMS = 170;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    typedef enum logic {
        ROW_REG_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    // One line of the directed table: a register write or a sample request.
    typedef struct {
        row_kind_t kind;
        int        arg;
        int        value;
        bit        typed;
        rsp_t      want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    req_t                     req       = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    rsp_t                     rsp;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Predictor state: register copies, held samples and their running total.
    logic          cur_mode;
    logic [6:0]    cur_window;
    int            held_samples [MAX_WINDOW_DEF];
    int            held_sum;
    int            held_count;
    int            held_ptr;

    rsp_t          pending_results [$];
    rsp_t          seen_want;
    int            send_idle_pct = 19;
    int            recv_idle_pct = 80;
    bit            long_hold     = 1'b0;
    int            results_checked = 0;
    int            mismatches      = 0;
    int            samples_sent    = 0;
    int            reg_writes      = 0;

    moving_average_smoother_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Window register values out of range clamp to 1 and to the delay line depth.
    function automatic int effective_window(input logic [6:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return int'(w);
    endfunction

    function automatic void restart_stream();
        held_sum   = 0;
        held_count = 0;
        held_ptr   = 0;
    endfunction

    // Append one expected result at the back of the queue.
    function automatic void queue_result(input rsp_t r);
        pending_results = {pending_results, r};
    endfunction

    // Work out the results one accepted sample causes; returns how many were queued.
    function automatic int predict_average(input req_t r);
        int   w;
        int   s;
        int   idx;
        int   got;
        int   pos;
        int   rem;
        bit   was_full;
        bit   emit;
        rsp_t res;
        w   = effective_window(cur_window);
        s   = int'($signed(r.sample));
        got = 0;
        // Window of one in centered mode: the sample is its own average, no tail.
        if (cur_mode == MODE_CENTERED && w == 1)
        begin
            queue_result({r.sample, r.last, 1'b0});
            if (r.last)
                restart_stream();
            return 1;
        end
        if (held_ptr >= w)
            held_ptr = 0;
        if (held_count > w)
            held_count = w;
        was_full = (held_count >= w);
        idx      = held_count;
        if (was_full)
            held_sum -= held_samples[held_ptr];
        held_samples[held_ptr] = s;
        held_sum += s;
        held_ptr++;
        if (held_ptr >= w)
            held_ptr = 0;
        if (!was_full)
            held_count++;
        if (cur_mode == MODE_TRAILING)
            emit = (held_count >= w);
        else
            emit = was_full || (idx > w / 2);
        if (emit)
        begin
            queue_result({16'(held_sum / held_count), 1'b0, 1'b0});
            got++;
        end
        if (r.last)
        begin
            if (held_count < w)
            begin
                // Stream ended before the window filled.
                queue_result({16'sd0, 1'b1, 1'b1});
                got++;
            end
            else
            begin
                // Centered tail: drop the oldest sample each step; empty window gives 0.
                if (cur_mode == MODE_CENTERED)
                begin
                    for (int k = 0; k <= w / 2; k++)
                    begin
                        pos = (held_ptr + k) % w;
                        rem = w - k - 1;
                        held_sum -= held_samples[pos];
                        queue_result(
                            {(rem != 0) ? 16'(held_sum / rem) : 16'sd0, 1'b0, 1'b0});
                        got++;
                    end
                end
                if (got > 0)
                begin
                    res = pending_results.pop_back();
                    res.last_out = 1'b1;
                    queue_result(res);
                end
            end
            restart_stream();
        end
        return got;
    endfunction

    // Drive one sample request, idling at random first, and wait until it is accepted.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic last_flag, output int produced);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= {value, last_flag};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        produced = predict_average({value, last_flag});
        samples_sent++;
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write request, issued only with the block idle.
    task automatic write_reg(input int index, input int data);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_BITS'(index);
        cfg_data  <= CFG_DATA_BITS'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (CFG_IDX_BITS'(index) == REG_MODE)
            cur_mode = data[0];
        else
            cur_window = 7'(data);
        restart_stream();
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t row(input row_kind_t kind, input int arg, input int value,
                                      input bit typed = 1'b0, input int avg = 0,
                                      input bit lst = 1'b0, input bit shrt = 1'b0);
        stim_row_t r;
        r.kind  = kind;
        r.arg   = arg;
        r.value = value;
        r.typed = typed;
        r.want  = {16'(avg), lst, shrt};
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        if (roll < 25)
            return 16'(int'($urandom_range(20)) - 10);
        return 16'($urandom);
    endfunction

    // Result side: random back-pressure, plus one long hold-off when asked.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Score every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: average %0d last_out %b too_short %b",
                       rsp.average, rsp.last_out, rsp.too_short);
                mismatches++;
            end
            else
            begin
                seen_want = pending_results.pop_front();
                results_checked++;
                if (rsp.average !== seen_want.average)
                begin
                    $error("average: expected %0d, got %0d", seen_want.average, rsp.average);
                    mismatches++;
                end
                if (rsp.last_out !== seen_want.last_out)
                begin
                    $error("last_out: expected %b, got %b", seen_want.last_out, rsp.last_out);
                    mismatches++;
                end
                if (rsp.too_short !== seen_want.too_short)
                begin
                    $error("too_short: expected %b, got %b", seen_want.too_short,
                           rsp.too_short);
                    mismatches++;
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence: reset, directed table, random streams, drain.
    initial
    begin
        stim_row_t   directed [$];
        int          produced;
        int          random_sent;
        int          streams_closed;
        int          phase_no;
        int          stream_total;
        int          len;
        int          eff;
        int          roll;
        bit          big_phase;
        bit          big_done;
        bit          closes;
        logic        new_mode;
        logic [6:0]  new_window;

        random_sent    = 0;
        streams_closed = 0;
        phase_no       = 0;
        big_done       = 1'b0;
        cur_mode       = MODE_RESET;
        cur_window     = WINDOW_RESET;
        restart_stream();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; starts from the reset setting of trailing mode, window 10.
        directed = {directed, row(ROW_SAMPLE, 100, 0)};
        directed = {directed, row(ROW_SAMPLE, -5, 1, 1'b1, 0, 1'b1, 1'b1)};
        directed = {directed, row(ROW_REG_WRITE, REG_WINDOW, 1)};
        directed = {directed, row(ROW_SAMPLE, 32767, 0, 1'b1, 32767)};
        directed = {directed, row(ROW_SAMPLE, -32768, 0, 1'b1, -32768)};
        directed = {directed, row(ROW_SAMPLE, -1, 1, 1'b1, -1, 1'b1)};
        directed = {directed, row(ROW_REG_WRITE, REG_WINDOW, 3)};
        directed = {directed, row(ROW_SAMPLE, 32767, 0)};
        directed = {directed, row(ROW_SAMPLE, 32767, 0)};
        directed = {directed, row(ROW_SAMPLE, 32767, 0)};
        directed = {directed, row(ROW_SAMPLE, -32768, 1)};
        // Centered mode with head, full windows and a shrinking tail.
        directed = {directed, row(ROW_REG_WRITE, REG_MODE, MODE_CENTERED)};
        directed = {directed, row(ROW_REG_WRITE, REG_WINDOW, 4)};
        directed = {directed, row(ROW_SAMPLE, -7, 0)};
        directed = {directed, row(ROW_SAMPLE, 3, 0)};
        directed = {directed, row(ROW_SAMPLE, 11, 0)};
        directed = {directed, row(ROW_SAMPLE, -20, 0)};
        directed = {directed, row(ROW_SAMPLE, 5, 1)};
        // Window two: the final tail window is empty and averages to zero.
        directed = {directed, row(ROW_REG_WRITE, REG_WINDOW, 2)};
        directed = {directed, row(ROW_SAMPLE, 9, 0)};
        directed = {directed, row(ROW_SAMPLE, -9, 0)};
        directed = {directed, row(ROW_SAMPLE, 4, 1)};
        // Short centered stream: a head result comes before the too-short flag.
        directed = {directed, row(ROW_REG_WRITE, REG_WINDOW, 6)};
        directed = {directed, row(ROW_SAMPLE, 1000, 0)};
        directed = {directed, row(ROW_SAMPLE, -2000, 0)};
        directed = {directed, row(ROW_SAMPLE, 3000, 0)};
        directed = {directed, row(ROW_SAMPLE, -4000, 0)};
        directed = {directed, row(ROW_SAMPLE, 5000, 1)};
        // Window zero behaves as one: centered samples pass straight through.
        directed = {directed, row(ROW_REG_WRITE, REG_WINDOW, 0)};
        directed = {directed, row(ROW_SAMPLE, -32768, 0, 1'b1, -32768)};
        directed = {directed, row(ROW_SAMPLE, 32767, 1, 1'b1, 32767, 1'b1)};

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_REG_WRITE)
                write_reg(directed[i].arg, directed[i].value);
            else
            begin
                send_sample(16'(directed[i].arg), 1'(directed[i].value), produced);
                // A typed row replaces what the predictor queued for it.
                if (directed[i].typed)
                begin
                    repeat (produced) void'(pending_results.pop_back());
                    queue_result(directed[i].want);
                end
            end
        end

        // Random phases: new settings, then one to three streams each.
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 80;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            big_phase = !big_done && (random_sent >= 2 * RANDOM_ITEMS / 3);
            if (phase_no == 0)
            begin
                new_mode   = MODE_TRAILING;
                new_window = 7'd2;
            end
            else if (big_phase)
            begin
                new_mode   = MODE_CENTERED;
                new_window = 7'($urandom_range(127, MAX_WINDOW_DEF));
            end
            else
            begin
                new_mode = 1'($urandom_range(1));
                roll     = $urandom_range(99);
                if (roll < 8)
                    new_window = 7'd0;
                else if (roll < 14)
                    new_window = 7'($urandom_range(127, MAX_WINDOW_DEF));
                else
                    new_window = 7'($urandom_range(12, 1));
            end

            if ($urandom_range(1) != 0)
            begin
                write_reg(REG_MODE, {6'($urandom), new_mode});
                write_reg(REG_WINDOW, new_window);
            end
            else
            begin
                write_reg(REG_WINDOW, new_window);
                write_reg(REG_MODE, {6'($urandom), new_mode});
            end
            eff = effective_window(new_window);

            // First phase: results pile up behind a long receiver hold-off.
            if (phase_no == 0)
                long_hold = 1'b1;

            stream_total = (phase_no == 0 || big_phase) ? 1 : $urandom_range(3, 1);
            for (int st = 0; st < stream_total; st++)
            begin
                closes = 1'b1;
                roll   = $urandom_range(99);
                if (phase_no == 0)
                    len = 24;
                else if (big_phase)
                    len = eff + $urandom_range(4);
                else if (eff == MAX_WINDOW_DEF)
                    len = $urandom_range(6, 1);
                else if (roll < 65 || eff == 1)
                    len = eff + $urandom_range(10);
                else if (roll < 85)
                    len = $urandom_range(eff - 1, 1);
                else
                begin
                    // Left open; the next register write aborts it.
                    len    = $urandom_range(eff + 5, 1);
                    closes = 1'b0;
                end
                for (int k = 0; k < len; k++)
                begin
                    send_sample(pick_sample(), closes && (k == len - 1), produced);
                    random_sent++;
                end
                if (!closes)
                    break;
                streams_closed++;
                if ($urandom_range(99) < 30)
                    wait_drained();
            end
            if (big_phase)
                big_done = 1'b1;
            phase_no++;
        end

        // Drain and settle.
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d sample requests (%0d random, %0d closed random streams), %0d writes,",
                 samples_sent, random_sent, streams_closed, reg_writes);
        $display("both modes, windows 0 through 127; %0d results checked, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
design/msu_pkg.sv
design/msu_div.sv
design/msu_dp.sv
design/msu_ctrl.sv
design/moving_average_smoother_unit.sv
design/msu_chk.sv
sim/tb_top.sv
